>>> hw/rtl/set_assoc_cache_nru_lookup_defines.svh
// Assertion macros for the NRU cache tag-store lookup.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_NRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_NRU_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sac_pkg.sv
// Shared types and constants for the NRU cache tag-store lookup.
// No dependencies; imported by the top level, sac_split and sac_nru.
package sac_pkg;

  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int WAY_IDX_W   = 4;   // covers up to 16 ways
  localparam int OUT_WAY_W   = 3;
  localparam int MISS_W      = 32;
  localparam int SET_FIELD_W = 15;  // index field before reduction modulo SETS
  localparam int RECIP_SHIFT = 26;  // fixed-point scale of the reciprocal
  localparam int REM_W       = 12;  // holds a remainder below twice SETS

  localparam logic [5:0] RST_ADDR_WIDTH   = 6'd32;
  localparam logic [4:0] RST_OFFSET_BITS  = 5'd4;
  localparam logic [3:0] RST_INDEX_BITS   = 4'd4;
  localparam logic [3:0] RST_WAYS_IN_USE  = 4'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDR_WIDTH   = 8'd0,
    REG_OFFSET_BITS  = 8'd1,
    REG_INDEX_BITS   = 8'd2,
    REG_WAYS_IN_USE  = 8'd3
  } sac_reg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } sac_state_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
  } sac_pick_t;

endpackage

>>> hw/rtl/set_assoc_cache_nru_lookup.sv
// Top level of the NRU set-associative cache tag-store lookup.
// Depends on sac_pkg, sac_ram, sac_split, sac_nru and the defines header.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | slave     | in_tvalid/in_tready  | in_tdata: address
//   out_    | master    | out_tvalid/out_tready| out_tdata: way, miss_total; tuser: hit
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An address passes these steps from transfer to result: split and reciprocal
// multiply, set read from the tag and status RAMs, then decision and
// write-back. A new address can enter while the last is in flight, but its
// set read waits until the last one's read / write-back round trip ends.
// After reset a clearing pass writes SETS status rows, one per cycle;
// no input transfer is taken until it ends.
// A stalled result holds the lookup stage, and that holds the input.
module set_assoc_cache_nru_lookup #(
  parameter int SETS      = 1024,
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // address
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  // way [2:0], miss_total [34:3], zero fill [39:35]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,
  // hit
  output logic                           out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sac_pkg::*;

  `include "set_assoc_cache_nru_lookup_defines.svh"

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TROW_W = WAYS * TAG_WIDTH;
  localparam int SROW_W = 2 * WAYS;   // {reference row, valid row}

  // Configuration registers
  logic [5:0] addr_width_r;
  logic [4:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_in_use_r;

  // Control
  sac_state_t        state_r, state_nxt;
  logic [SET_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic              s1_valid_r;
  logic              s2_valid_r;
  logic              out_valid_r;
  logic              s1_advance;
  logic              s2_advance;
  logic              rd_en;

  // Payload
  logic [SET_W-1:0]     s1_set;
  logic [TAG_WIDTH-1:0] s1_tag;
  logic [SET_W-1:0]     s2_set_r;
  logic [TAG_WIDTH-1:0] s2_tag_r;
  logic                 out_hit_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic [MISS_W-1:0]    miss_r, miss_nxt;

  // RAM ports
  logic              tag_we;
  logic [TROW_W-1:0] tag_rdata;
  logic [TROW_W-1:0] tag_wdata;
  logic              st_we;
  logic [SET_W-1:0]  st_waddr;
  logic [SROW_W-1:0] st_wdata;
  logic [SROW_W-1:0] st_rdata;

  sac_pick_t         pick;
  logic [WAYS-1:0]   valid_new;
  logic [WAYS-1:0]   ref_new;

  // Configuration: always ready; user must write only while block is idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_width_r   <= RST_ADDR_WIDTH;
      offset_bits_r  <= RST_OFFSET_BITS;
      index_bits_r   <= RST_INDEX_BITS;
      ways_in_use_r  <= RST_WAYS_IN_USE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADDR_WIDTH:   addr_width_r   <= cfg_data[5:0];
        REG_OFFSET_BITS:  offset_bits_r  <= cfg_data[4:0];
        REG_INDEX_BITS:   index_bits_r   <= cfg_data[3:0];
        REG_WAYS_IN_USE:  ways_in_use_r  <= cfg_data[3:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Stage handshakes. A set read waits until the lookup stage is empty, so
  // a read never meets a write-back of the same set still in flight.
  assign s2_advance = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_advance = s1_valid_r && !s2_valid_r;
  assign rd_en      = s1_advance;
  assign in_tready  = (state_r == ST_RUN) && (!s1_valid_r || s1_advance);
  assign tag_we     = s2_advance;

  sac_split #(
    .SETS      (SETS),
    .TAG_WIDTH (TAG_WIDTH),
    .SET_W     (SET_W)
  ) u_split (
    .clk          (clk),
    .load         (in_tvalid && in_tready),
    .address      (in_tdata),
    .addr_width   (addr_width_r),
    .offset_bits  (offset_bits_r),
    .index_bits   (index_bits_r),
    .set_idx      (s1_set),
    .tag          (s1_tag)
  );

  sac_ram #(
    .WIDTH (TROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (s2_set_r),
    .wdata (tag_wdata),
    .re    (rd_en),
    .raddr (s1_set),
    .rdata (tag_rdata)
  );

  sac_ram #(
    .WIDTH (SROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (s1_set),
    .rdata (st_rdata)
  );

  sac_nru #(
    .WAYS      (WAYS),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_nru (
    .tag         (s2_tag_r),
    .tag_row     (tag_rdata),
    .valid_row   (st_rdata[WAYS-1:0]),
    .ref_row     (st_rdata[SROW_W-1:WAYS]),
    .ways_in_use (ways_in_use_r),
    .pick        (pick),
    .tag_row_new (tag_wdata),
    .valid_new   (valid_new),
    .ref_new     (ref_new)
  );

  // Clearing pass and status write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    st_we       = 1'b0;
    st_waddr    = s2_set_r;
    st_wdata    = {ref_new, valid_new};
    case (state_r)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx_r;
        st_wdata = '0;
        if (clr_idx_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_RUN;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_RUN: begin
        st_we = s2_advance;
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_idx_nxt = '0;
      end
    endcase
  end

  // Stage valids and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      miss_r      <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        s2_valid_r <= 1'b1;
      end else if (s2_advance) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      miss_r <= miss_nxt;
    end
  end

  // Count a miss, hold at the top of the range.
  always_comb begin
    miss_nxt = miss_r;
    if (s2_advance && !pick.hit && (miss_r != {MISS_W{1'b1}})) begin
      miss_nxt = miss_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_set_r <= s1_set;
      s2_tag_r <= s1_tag;
    end
    if (s2_advance) begin
      out_hit_r <= pick.hit;
      out_way_r <= pick.way[OUT_WAY_W-1:0];
    end
  end

  // The miss count changes only when a new result is loaded, so it serves
  // directly as the result field.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {5'd0, miss_r, out_way_r};

  `SAC_ASSERT_NOW(a_no_rw_overlap, tag_we, !rd_en, "set read overlaps write-back")
  `SAC_ASSERT_NOW(a_hold_in_clear, state_r == ST_CLEAR, !in_tready, "input taken during clear")
  `SAC_ASSERT_NEXT(a_miss_monotonic, 1'b1, miss_r >= $past(miss_r), "miss count fell")
  `SAC_ASSERT_NEXT(a_hit_keeps_count, s2_advance && pick.hit, miss_r == $past(miss_r), "hit changed miss count")

endmodule

>>> hw/rtl/sac_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the tag and status stores.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/sac_split.sv
// Address split: masks the address, extracts index field and tag, and
// reduces the index modulo SETS across its input register. Depends on sac_pkg.
module sac_split #(
  parameter int SETS      = 1024,
  parameter int TAG_WIDTH = 32,
  parameter int SET_W     = 10
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [sac_pkg::ADDR_W-1:0] address,
  input  logic [5:0]                addr_width,
  input  logic [4:0]                offset_bits,
  input  logic [3:0]                index_bits,
  output logic [SET_W-1:0]          set_idx,
  output logic [TAG_WIDTH-1:0]      tag
);

  import sac_pkg::*;

  localparam int    PROD_W  = SET_FIELD_W + RECIP_SHIFT + 1;
  localparam int    BACK_W  = SET_FIELD_W + REM_W;
  localparam longint RECIP  = (longint'(1) << RECIP_SHIFT) / SETS;

  logic [5:0]             abits;
  logic [ADDR_W-1:0]      addr_mask;
  logic [ADDR_W-1:0]      idx_mask;
  logic [ADDR_W-1:0]      above;
  logic [ADDR_W-1:0]      tag_full;
  logic [PROD_W-1:0]      prod;
  logic [SET_FIELD_W-1:0] field_nxt, field_r;
  logic [SET_FIELD_W-1:0] quot_nxt, quot_r;
  logic [TAG_WIDTH-1:0]   tag_nxt, tag_r;
  logic [SET_FIELD_W-1:0] back;
  logic [SET_FIELD_W-1:0] diff;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_fix;

  // Before the register: mask, shift, multiply by the scaled reciprocal of SETS.
  always_comb begin
    abits     = (addr_width > 6'd32) ? 6'd32 : addr_width;
    addr_mask = ~({ADDR_W{1'b1}} << abits);
    above     = (address & addr_mask) >> offset_bits;
    idx_mask  = ~({ADDR_W{1'b1}} << index_bits);
    field_nxt = SET_FIELD_W'(above & idx_mask);
    tag_full  = above >> index_bits;
    tag_nxt   = TAG_WIDTH'(tag_full);
    prod      = PROD_W'(field_nxt) * PROD_W'(RECIP);
    quot_nxt  = prod[RECIP_SHIFT +: SET_FIELD_W];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      field_r <= field_nxt;
      quot_r  <= quot_nxt;
      tag_r   <= tag_nxt;
    end
  end

  // After the register: the quotient is exact or one short, so one correction
  // step leaves the true remainder.
  always_comb begin
    back    = SET_FIELD_W'(BACK_W'(quot_r) * BACK_W'(SETS));
    diff    = field_r - back;
    rem     = REM_W'(diff);
    rem_fix = (rem >= REM_W'(SETS)) ? (rem - REM_W'(SETS)) : rem;
    set_idx = SET_W'(rem_fix);
  end

  assign tag = tag_r;

endmodule

>>> hw/rtl/sac_nru.sv
// Way selection for one set: tag compare, fill or NRU victim choice, and
// the updated tag, valid and reference rows. Depends on sac_pkg.
module sac_nru #(
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 32
) (
  input  logic [TAG_WIDTH-1:0]      tag,
  input  logic [WAYS*TAG_WIDTH-1:0] tag_row,
  input  logic [WAYS-1:0]           valid_row,
  input  logic [WAYS-1:0]           ref_row,
  input  logic [3:0]                ways_in_use,
  output sac_pkg::sac_pick_t        pick,
  output logic [WAYS*TAG_WIDTH-1:0] tag_row_new,
  output logic [WAYS-1:0]           valid_new,
  output logic [WAYS-1:0]           ref_new
);

  import sac_pkg::*;

  logic [4:0]           nways;
  logic [WAYS-1:0]      in_use;
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      inv;
  logic [WAYS-1:0]      ref_eff;
  logic [WAYS-1:0]      cand;
  logic                 all_set;
  logic                 hit;
  logic                 found;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] inv_way;
  logic [WAY_IDX_W-1:0] vic_way;
  logic [WAY_IDX_W-1:0] chosen;

  always_comb begin
    // Clamp the associativity setting into one..WAYS.
    if (ways_in_use == 4'd0) begin
      nways = 5'd1;
    end else if (5'(ways_in_use) > 5'(WAYS)) begin
      nways = 5'(WAYS);
    end else begin
      nways = 5'(ways_in_use);
    end

    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (5'(w) < nways);
      match[w]  = in_use[w] && valid_row[w] &&
                  (tag_row[w*TAG_WIDTH +: TAG_WIDTH] == tag);
      inv[w]    = in_use[w] && !valid_row[w];
    end

    all_set = &(ref_row | ~in_use);
    ref_eff = all_set ? (ref_row & ~in_use) : ref_row;
    cand    = in_use & ~ref_eff;
    hit     = |match;
    found   = |inv;

    // Lowest set bit wins: scan from the top down.
    hit_way = '0;
    inv_way = '0;
    vic_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_IDX_W'(w);
      if (inv[w])   inv_way = WAY_IDX_W'(w);
      if (cand[w])  vic_way = WAY_IDX_W'(w);
    end

    tag_row_new = tag_row;
    valid_new   = valid_row;
    ref_new     = ref_row;
    if (hit) begin
      chosen = hit_way;
    end else if (found) begin
      chosen = inv_way;
    end else begin
      chosen  = vic_way;
      ref_new = ref_eff;
    end

    for (int w = 0; w < WAYS; w++) begin
      if (WAY_IDX_W'(w) == chosen) begin
        if (hit) begin
          ref_new[w] = 1'b1;
        end else begin
          tag_row_new[w*TAG_WIDTH +: TAG_WIDTH] = tag;
          if (found) valid_new[w] = 1'b1;
        end
      end
    end

    pick.hit = hit;
    pick.way = chosen;
  end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the NRU set-associative cache tag-store lookup.
// Drives addresses and register writes and checks every result against a local
// copy of the tag store; depends on sac_pkg and set_assoc_cache_nru_lookup.
module tb_top;
  import sac_pkg::*;

  localparam int N_SETS        = 1024;
  localparam int N_WAYS        = 8;
  localparam int TAG_W         = 32;
  localparam int N_PHASES      = 9;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 4;      // lets the lookup pipeline empty
  localparam int HOLD_CYCLES   = 200;    // long receiver hold-off
  localparam int DRAIN_LIMIT   = 5000;
  localparam longint WATCHDOG  = 64'd4_000_000;

  // One lookup outcome as the block reports it
  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [MISS_W-1:0]    misses;
  } lookup_t;

  // One row of the directed stimulus: either a register write or an address
  typedef struct {
    bit                    is_cfg;
    sac_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic [ADDR_W-1:0]     addr;
    bit                    typed;    // expected result written into the row
    lookup_t               want;
  } stim_row_t;

  // Block inputs start at known values; rst_n is held low from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [ADDR_W-1:0]     in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  sac_reg_t              cfg_index  = REG_ADDR_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [39:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_ready;

  // Local copy of the cache state and of the registers
  logic [TAG_W-1:0]  tag_mem   [N_SETS*N_WAYS];
  bit                valid_mem [N_SETS*N_WAYS];
  bit                ref_mem   [N_SETS*N_WAYS];
  logic [MISS_W-1:0] miss_tally = '0;
  logic [5:0]        reg_abits  = RST_ADDR_WIDTH;
  logic [4:0]        reg_offset = RST_OFFSET_BITS;
  logic [3:0]        reg_ixbits = RST_INDEX_BITS;
  logic [3:0]        reg_ways   = RST_WAYS_IN_USE;

  lookup_t           pending_results[$];
  stim_row_t         directed_rows[$];
  logic [ADDR_W-1:0] hot_addr[$];
  int                n_errors      = 0;
  int                send_idle_pct = 20;
  int                recv_idle_pct = 77;
  bit                hold_toggle   = 1'b0;   // flipped by the sender to ask for a hold-off
  bit                hold_seen     = 1'b0;
  int                hold_left     = 0;

  set_assoc_cache_nru_lookup #(
    .SETS      (N_SETS),
    .WAYS      (N_WAYS),
    .TAG_WIDTH (TAG_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Work out the result of one lookup and advance the local cache state.
  // The address is split with the registers as they stand at the transfer.
  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    int      abits;
    int      nways;
    int      base;
    int      pick;
    logic [63:0] kept;
    logic [63:0] above;
    logic [63:0] set_no;
    logic [63:0] tagv;
    bit      hit_f;
    bit      free_f;
    bit      clear_f;
    bit      all_ref;
    lookup_t res;
    // Address width above 32 acts as 32; zero keeps no bits at all
    abits  = (reg_abits > 6'd32) ? 32 : int'(reg_abits);
    kept   = {32'd0, addr} & ((64'd1 << abits) - 64'd1);
    // 64-bit shifts so that splits reaching past bit 31 read as zero
    above  = kept >> reg_offset;
    set_no = (above & ((64'd1 << reg_ixbits) - 64'd1)) % N_SETS;
    tagv   = (above >> reg_ixbits) & ((64'd1 << TAG_W) - 64'd1);
    nways  = (reg_ways == 4'd0) ? 1 : (reg_ways > N_WAYS) ? N_WAYS : int'(reg_ways);
    base   = int'(set_no) * N_WAYS;
    hit_f  = 1'b0;
    pick   = 0;
    // Lowest matching valid way wins, so duplicates hit on the lower way
    for (int w = 0; w < nways; w++) begin
      if (!hit_f && valid_mem[base+w] && tag_mem[base+w] == tagv[TAG_W-1:0]) begin
        hit_f = 1'b1;
        pick  = w;
      end
    end
    if (hit_f) begin
      ref_mem[base+pick] = 1'b1;
    end else begin
      if (miss_tally != '1) miss_tally++;
      free_f = 1'b0;
      for (int w = 0; w < nways; w++) begin
        if (!free_f && !valid_mem[base+w]) begin
          free_f = 1'b1;
          pick   = w;
        end
      end
      if (free_f) begin
        valid_mem[base+pick] = 1'b1;
        tag_mem[base+pick]   = tagv[TAG_W-1:0];
      end else begin
        // Every way referenced: age the whole set before choosing a victim
        all_ref = 1'b1;
        for (int w = 0; w < nways; w++) if (!ref_mem[base+w]) all_ref = 1'b0;
        if (all_ref) for (int w = 0; w < nways; w++) ref_mem[base+w] = 1'b0;
        clear_f = 1'b0;
        for (int w = 0; w < nways; w++) begin
          if (!clear_f && !ref_mem[base+w]) begin
            clear_f = 1'b1;
            pick    = w;
          end
        end
        tag_mem[base+pick] = tagv[TAG_W-1:0];
      end
    end
    res.hit    = hit_f;
    res.way    = 3'(pick);
    res.misses = miss_tally;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic row_cfg(input sac_reg_t r, input logic [CFG_DATA_W-1:0] d);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = r;
    row.value   = d;
    row.addr    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endtask

  task automatic row_addr(input logic [ADDR_W-1:0] a, input bit typed, input bit hit,
                          input logic [OUT_WAY_W-1:0] way, input logic [MISS_W-1:0] misses);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.reg_sel     = REG_ADDR_WIDTH;
    row.value       = '0;
    row.addr        = a;
    row.typed       = typed;
    row.want.hit    = hit;
    row.want.way    = way;
    row.want.misses = misses;
    directed_rows.push_back(row);
  endtask

  // Raise the write and hold it until the transfer; the caller drops cfg_valid
  // after the last write of a group so that back-to-back writes stay high.
  task automatic write_reg(input sac_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_ADDR_WIDTH:   reg_abits  = d[5:0];
      REG_OFFSET_BITS:  reg_offset = d[4:0];
      REG_INDEX_BITS:   reg_ixbits = d[3:0];
      REG_WAYS_IN_USE:  reg_ways   = d[3:0];
      default: ;
    endcase
  endtask

  // Offer one address, idling first at the current rate, and record what the
  // block must answer once the transfer has happened.
  task automatic send_address(input logic [ADDR_W-1:0] a, input bit typed,
                              input lookup_t want);
    lookup_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    predicted = predict_lookup(a);
    // A typed row still advances the local state but checks its own value
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait for every outstanding result, then let the
  // pipeline settle so that a register write finds the block idle.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: drive tready, honour hold-off requests and check each transfer
  // against the oldest pending expectation, field by field.
  always @(posedge clk) begin : rx
    lookup_t want;
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.hit)
          report_mismatch("hit", 64'(out_tuser), 64'(want.hit));
        if (out_tdata[2:0] !== want.way)
          report_mismatch("way", 64'(out_tdata[2:0]), 64'(want.way));
        if (out_tdata[34:3] !== want.misses)
          report_mismatch("miss_total", 64'(out_tdata[34:3]), 64'(want.misses));
        if (out_tdata[39:35] !== 5'd0)
          report_mismatch("tdata fill", 64'(out_tdata[39:35]), 64'd0);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included
  initial begin
    #(WATCHDOG);
    $display("set_assoc_cache_nru_lookup test failed");
    $finish;
  end

  initial begin
    lookup_t     no_want;
    logic [5:0]  v_ab;
    logic [4:0]  v_off;
    logic [3:0]  v_ix;
    logic [3:0]  v_ways;
    logic [31:0] base_addr;
    logic [31:0] vary_mask;
    logic [31:0] a;
    int          n_hot;
    no_want = '0;

    // Directed part, reset split: offset 4, index 4, four ways.
    // Empty cache: first access misses into way 0, repeat hits it
    row_addr(32'h0000_0000, 1, 1'b0, 3'd0, 32'd1);
    row_addr(32'h0000_0000, 1, 1'b1, 3'd0, 32'd1);
    // All-ones address lands in set 15, still empty
    row_addr(32'hFFFF_FFFF, 1, 1'b0, 3'd0, 32'd2);
    // Offset bits are ignored: same block as address zero
    row_addr(32'h0000_000F, 1, 1'b1, 3'd0, 32'd2);
    // Fill set 0, then miss with the set full and only way 0 referenced
    row_addr(32'h0000_0100, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0200, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0300, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0400, 0, 1'b0, 3'd0, 32'd0);
    // Reference every way, then miss: all bits clear and way 0 is replaced
    row_addr(32'h0000_0000, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0400, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0200, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0300, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_0500, 0, 1'b0, 3'd0, 32'd0);
    // Duplicate tags: narrow to one way, replace way 0 with the tag held in
    // way 1, widen again and hit on the lower copy
    row_cfg(REG_WAYS_IN_USE, 8'd2);
    row_addr(32'h0000_1010, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h0000_2010, 0, 1'b0, 3'd0, 32'd0);
    row_cfg(REG_WAYS_IN_USE, 8'd1);
    row_addr(32'h0000_2010, 0, 1'b0, 3'd0, 32'd0);
    row_cfg(REG_WAYS_IN_USE, 8'd2);
    row_addr(32'h0000_2010, 0, 1'b0, 3'd0, 32'd0);
    // Ways setting of zero acts as one, above the maximum acts as eight
    row_cfg(REG_WAYS_IN_USE, 8'd0);
    row_addr(32'h0000_3010, 0, 1'b0, 3'd0, 32'd0);
    row_cfg(REG_WAYS_IN_USE, 8'd15);
    row_addr(32'h0000_3010, 0, 1'b0, 3'd0, 32'd0);
    // Address width above 32, then zero: every address reads as zero
    row_cfg(REG_ADDR_WIDTH, 8'd40);
    row_addr(32'h0000_4010, 0, 1'b0, 3'd0, 32'd0);
    row_cfg(REG_ADDR_WIDTH, 8'd0);
    row_addr(32'hFFFF_FFFF, 0, 1'b0, 3'd0, 32'd0);
    row_addr(32'h1234_5678, 0, 1'b0, 3'd0, 32'd0);

    // Hold reset, then release it once; the block clears its status rows
    // itself and holds in_tready low until that pass is over
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_results_drained();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
        cfg_valid <= 1'b0;
      end else begin
        send_address(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: each phase sets all four registers, then streams
    // addresses drawn mostly from a small pool that collides in a few sets
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Receiver-heavy idling first, then sender-heavy, then none
      case (ph / 3)
        0: begin send_idle_pct <= 20; recv_idle_pct <= 77; end
        1: begin send_idle_pct <= 77; recv_idle_pct <= 20; end
        default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
      endcase
      case (ph)
        0: begin v_ab = 6'd32; v_off = 5'd4;  v_ix = 4'd2;  v_ways = 4'd8;  end
        // Nothing significant: one address, one way
        1: begin v_ab = 6'd0;  v_off = 5'd0;  v_ix = 4'd0;  v_ways = 4'd0;  end
        // Widest settings: split reaches the top of the address, index wraps
        3: begin v_ab = 6'd63; v_off = 5'd17; v_ix = 4'd15; v_ways = 4'd15; end
        // Every set in use, no offset
        4: begin v_ab = 6'd32; v_off = 5'd0;  v_ix = 4'd10; v_ways = 4'd8;  end
        6: begin v_ab = 6'd1;  v_off = 5'd0;  v_ix = 4'd1;  v_ways = 4'd1;  end
        8: begin v_ab = 6'd12; v_off = 5'd3;  v_ix = 4'd2;  v_ways = 4'd3;  end
        default: begin
          v_ab   = 6'($urandom_range(8, 32));
          v_off  = 5'($urandom_range(0, 8));
          v_ix   = 4'($urandom_range(0, 10));
          v_ways = 4'($urandom_range(1, 8));
        end
      endcase
      wait_results_drained();
      // Upper write-data bits are don't-care; toggle them anyway
      write_reg(REG_ADDR_WIDTH,   {2'($urandom), v_ab});
      write_reg(REG_OFFSET_BITS,  {3'($urandom), v_off});
      write_reg(REG_INDEX_BITS,   {4'($urandom), v_ix});
      write_reg(REG_WAYS_IN_USE,  {4'($urandom), v_ways});
      cfg_valid <= 1'b0;

      // Pool of addresses that differ only in at most six random bit positions
      n_hot     = $urandom_range(6, 24);
      base_addr = $urandom;
      vary_mask = '0;
      repeat (6) vary_mask[$urandom_range(31)] = 1'b1;
      hot_addr.delete();
      repeat (n_hot) hot_addr.push_back(base_addr ^ ($urandom & vary_mask));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Once per idling mode, stall the receiver long enough to back up
        // the pipeline while addresses keep coming
        if (k == 20 && ph % 3 == 1) hold_toggle <= ~hold_toggle;
        // Mid-phase, pause until every result is back
        if (k == PHASE_ITEMS / 2) wait_results_drained();
        if ($urandom_range(99) < 80) a = hot_addr[$urandom_range(hot_addr.size() - 1)];
        else a = $urandom;
        send_address(a, 1'b0, no_want);
      end
    end

    // Drain: wait for the last results, then a few cycles for strays
    in_tvalid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);

    if (n_errors == 0) begin
      $display("set_assoc_cache_nru_lookup test passed");
    end else begin
      $display("set_assoc_cache_nru_lookup test failed");
    end
    $finish;
  end

endmodule
